@@ hw/rtl/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and reset values of the slot allocator with free stack.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  // Fixed field widths.
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 12;
  localparam int STATUS_W = 3;
  localparam int GRANT_W  = 10;
  localparam int CNT_W    = 11;
  localparam int STRIDE_W = 12;
  localparam int ADDR_W   = 64;
  localparam int PROD_W   = SLOT_W + STRIDE_W;

  // Configuration port.
  localparam int PADDR_W  = 6;
  localparam int PDATA_W  = 64;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

  localparam logic [CNT_W-1:0]    CAPACITY_RST = 11'd1024;
  localparam logic [STRIDE_W-1:0] STRIDE_RST   = 12'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC     = 2'd0,
    FUNC_FREE      = 2'd1,
    FUNC_CPU_QUERY = 2'd2,
    FUNC_GPU_QUERY = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_VISIBLE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]    capacity;
    logic [STRIDE_W-1:0] stride_bytes;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
    logic                shader_visible;
  } cfg_t;

endpackage

@@ hw/rtl/slot_allocator_free_stack_unit.sv @@
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_unit
// Slot index allocator with a LIFO free stack and handle address queries.
// ----------------------------------------------------------------------------
// Usage: a request (func, slot) is taken at a rising edge with start high
// and busy low. Its one result (status, granted, handle) appears on the
// result ports in the following cycle, marked by done for exactly one
// cycle; the receiver must take it then, as it cannot hold results off.
// busy is high during that result cycle, so no new request is accepted
// while a result is shown. The result cycle is set by the free stack
// memory, whose read data is registered: a pop reads the stack top in the
// accept cycle and the index is available in the result cycle.
// Handle queries register slot times stride in the accept cycle and add the
// base in the result cycle.
// Configuration goes through the APB port at byte addresses 8*i (64-bit
// data): capacity, stride_bytes, cpu_base, gpu_base, shader_visible. Write
// it only while no transaction is in flight.
// Reset clears the stack depth, bump pointer and live count and loads the
// register defaults; the free stack memory needs no clearing because only
// entries below the stack depth are ever used as a result.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_unit #(
  parameter int MAX_SLOTS = sfs_pkg::MAX_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sfs_pkg::FUNC_W-1:0]     func,
  input  logic [sfs_pkg::SLOT_W-1:0]     slot,
  output logic                           done,
  output logic [sfs_pkg::STATUS_W-1:0]   status,
  output logic [sfs_pkg::GRANT_W-1:0]    granted,
  output logic [sfs_pkg::ADDR_W-1:0]     handle,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfs_pkg::PADDR_W-1:0]    paddr,
  input  logic [sfs_pkg::PDATA_W-1:0]    pwdata,
  output logic [sfs_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  sfs_pkg::cfg_t                   cfg;
  logic [sfs_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            cfg_wr;
  logic                            load;
  logic                            query_ok;
  logic                            ram_we;
  logic [AW-1:0]                   ram_addr;
  logic [sfs_pkg::GRANT_W-1:0]     ram_wdata;
  logic [sfs_pkg::GRANT_W-1:0]     ram_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sfs_pkg::PADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity       <= sfs_pkg::CAPACITY_RST;
      cfg.stride_bytes   <= sfs_pkg::STRIDE_RST;
      cfg.cpu_base       <= '0;
      cfg.gpu_base       <= '0;
      cfg.shader_visible <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        sfs_pkg::REG_CAPACITY:       cfg.capacity <= pwdata[sfs_pkg::CNT_W-1:0];
        sfs_pkg::REG_STRIDE:         cfg.stride_bytes <= pwdata[sfs_pkg::STRIDE_W-1:0];
        sfs_pkg::REG_CPU_BASE:       cfg.cpu_base <= pwdata;
        sfs_pkg::REG_GPU_BASE:       cfg.gpu_base <= pwdata;
        sfs_pkg::REG_SHADER_VISIBLE: cfg.shader_visible <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfs_pkg::REG_CAPACITY:       prdata = sfs_pkg::PDATA_W'(cfg.capacity);
      sfs_pkg::REG_STRIDE:         prdata = sfs_pkg::PDATA_W'(cfg.stride_bytes);
      sfs_pkg::REG_CPU_BASE:       prdata = cfg.cpu_base;
      sfs_pkg::REG_GPU_BASE:       prdata = cfg.gpu_base;
      sfs_pkg::REG_SHADER_VISIBLE: prdata = sfs_pkg::PDATA_W'(cfg.shader_visible);
      default:                     prdata = '0;
    endcase
  end

  sfs_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .slot      (slot),
    .cfg       (cfg),
    .busy      (busy),
    .done      (done),
    .load      (load),
    .query_ok  (query_ok),
    .status    (status),
    .granted   (granted),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  sfs_ram #(
    .WIDTH (sfs_pkg::GRANT_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sfs_handle u_handle (
    .clk      (clk),
    .load     (load),
    .query_ok (query_ok),
    .func     (func),
    .slot     (slot),
    .cfg      (cfg),
    .handle   (handle)
  );

endmodule

@@ hw/rtl/sfs_ram.sv @@
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/sfs_handle.sv @@
// ----------------------------------------------------------------------------
// sfs_handle
// Handle address unit: registers slot times stride, then adds the base.
// ----------------------------------------------------------------------------
module sfs_handle (
  input  logic                             clk,
  input  logic                             load,
  input  logic                             query_ok,
  input  logic [sfs_pkg::FUNC_W-1:0]       func,
  input  logic [sfs_pkg::SLOT_W-1:0]       slot,
  input  sfs_pkg::cfg_t                    cfg,
  output logic [sfs_pkg::ADDR_W-1:0]       handle
);

  logic [sfs_pkg::PROD_W-1:0] prod;
  logic [sfs_pkg::ADDR_W-1:0] base;
  logic                       ok;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= sfs_pkg::PROD_W'(slot) * sfs_pkg::PROD_W'(cfg.stride_bytes);
      base <= (func == sfs_pkg::FUNC_GPU_QUERY) ? cfg.gpu_base : cfg.cpu_base;
      ok   <= query_ok;
    end
  end

  // The sum wraps modulo 2^64.
  assign handle = ok ? (base + sfs_pkg::ADDR_W'(prod)) : '0;

endmodule

@@ hw/rtl/sfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfs_ctrl
// Request sequencer: counters, free stack access and status decisions.
// ----------------------------------------------------------------------------
module sfs_ctrl #(
  parameter int MAX_SLOTS = sfs_pkg::MAX_SLOTS_DEF,
  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int DEPTH_W = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sfs_pkg::FUNC_W-1:0]    func,
  input  logic [sfs_pkg::SLOT_W-1:0]    slot,
  input  sfs_pkg::cfg_t                 cfg,
  output logic                          busy,
  output logic                          done,
  output logic                          load,
  output logic                          query_ok,
  output logic [sfs_pkg::STATUS_W-1:0]  status,
  output logic [sfs_pkg::GRANT_W-1:0]   granted,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_addr,
  output logic [sfs_pkg::GRANT_W-1:0]   ram_wdata,
  input  logic [sfs_pkg::GRANT_W-1:0]   ram_rdata
);

  localparam int CMP_W = (DEPTH_W > sfs_pkg::SLOT_W) ? DEPTH_W : sfs_pkg::SLOT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state, state_next;

  logic [DEPTH_W-1:0]             stack_depth, stack_depth_next;
  logic [sfs_pkg::CNT_W-1:0]      bump_next, bump_next_next;
  logic [sfs_pkg::CNT_W-1:0]      live_count, live_count_next;
  logic [sfs_pkg::STATUS_W-1:0]   status_r, status_next;
  logic [sfs_pkg::GRANT_W-1:0]    granted_r, granted_next;
  logic                           pop_r, pop;
  logic                           accept;
  logic [DEPTH_W-1:0]             depth_dec;
  logic [CMP_W-1:0]               cap_raw, max_w, cap_eff;
  logic [CMP_W-1:0]               live_w, bump_w, depth_w, slot_w;

  assign accept    = start && !busy;
  assign load      = accept;
  assign depth_dec = stack_depth - 1'b1;

  // The capacity register is limited to the stack size.
  assign cap_raw = CMP_W'(cfg.capacity);
  assign max_w   = CMP_W'(MAX_SLOTS);
  assign cap_eff = (cap_raw > max_w) ? max_w : cap_raw;
  assign live_w  = CMP_W'(live_count);
  assign bump_w  = CMP_W'(bump_next);
  assign depth_w = CMP_W'(stack_depth);
  assign slot_w  = CMP_W'(slot);

  always_comb begin
    state_next       = state;
    stack_depth_next = stack_depth;
    bump_next_next   = bump_next;
    live_count_next  = live_count;
    status_next      = sfs_pkg::ST_OK;
    granted_next     = '0;
    pop              = 1'b0;
    query_ok         = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = stack_depth[AW-1:0];
    ram_wdata        = slot[sfs_pkg::GRANT_W-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RESP;
          case (func)
            sfs_pkg::FUNC_ALLOC: begin
              if (live_w >= cap_eff) begin
                status_next = sfs_pkg::ST_FULL;
              end else if (stack_depth != '0) begin
                // The popped index comes from the registered stack read in the result cycle.
                pop              = 1'b1;
                ram_addr         = depth_dec[AW-1:0];
                stack_depth_next = depth_dec;
                live_count_next  = live_count + 1'b1;
              end else if (bump_w >= cap_eff) begin
                status_next = sfs_pkg::ST_FULL;
              end else begin
                granted_next    = bump_next[sfs_pkg::GRANT_W-1:0];
                bump_next_next  = bump_next + 1'b1;
                live_count_next = live_count + 1'b1;
              end
            end
            sfs_pkg::FUNC_FREE: begin
              if (slot_w >= cap_eff) begin
                status_next = sfs_pkg::ST_BAD_INDEX;
              end else if (depth_w >= max_w) begin
                status_next = sfs_pkg::ST_OVERFLOW;
              end else begin
                ram_we           = 1'b1;
                stack_depth_next = stack_depth + 1'b1;
                if (live_count != '0) begin
                  live_count_next = live_count - 1'b1;
                end
              end
            end
            sfs_pkg::FUNC_CPU_QUERY: begin
              if (slot_w >= cap_eff) begin
                status_next = sfs_pkg::ST_BAD_INDEX;
              end else begin
                query_ok = 1'b1;
              end
            end
            sfs_pkg::FUNC_GPU_QUERY: begin
              if (!cfg.shader_visible) begin
                status_next = sfs_pkg::ST_NOT_VISIBLE;
              end else if (slot_w >= cap_eff) begin
                status_next = sfs_pkg::ST_BAD_INDEX;
              end else begin
                query_ok = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_depth <= '0;
      bump_next   <= '0;
      live_count  <= '0;
    end else begin
      state       <= state_next;
      stack_depth <= stack_depth_next;
      bump_next   <= bump_next_next;
      live_count  <= live_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_next;
      granted_r <= granted_next;
      pop_r     <= pop;
    end
  end

  assign busy    = (state == S_RESP);
  assign done    = (state == S_RESP);
  assign status  = status_r;
  assign granted = pop_r ? ram_rdata : granted_r;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted transaction produced no result");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(stack_depth) <= max_w)
    else $error("free stack depth beyond its size");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && func == sfs_pkg::FUNC_FREE && status_next == sfs_pkg::ST_OK)
    |=> stack_depth == $past(stack_depth) + 1'b1)
    else $error("successful free did not push");

  a_alloc_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && func == sfs_pkg::FUNC_ALLOC && status_next == sfs_pkg::ST_OK)
    |=> live_count == $past(live_count) + 1'b1)
    else $error("successful allocate did not raise the live count");

endmodule

@@ tb/slot_alloc_checker.sv @@
// ----------------------------------------------------------------------------
// slot_alloc_checker
// Watches the request, result and register ports of the slot allocator. It
// keeps its own copy of the free stack, the counters and the registers,
// predicts the outcome of every accepted request and compares each result
// with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_alloc_checker #(
  parameter int MAX_SLOTS = sfs_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [sfs_pkg::FUNC_W-1:0]   func,
  input  logic [sfs_pkg::SLOT_W-1:0]   slot,
  input  logic                         done,
  input  logic [sfs_pkg::STATUS_W-1:0] status,
  input  logic [sfs_pkg::GRANT_W-1:0]  granted,
  input  logic [sfs_pkg::ADDR_W-1:0]   handle,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [sfs_pkg::PADDR_W-1:0]  paddr,
  input  logic [sfs_pkg::PDATA_W-1:0]  pwdata,
  output int                           errors,
  output int                           pending
);
  import sfs_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted;
    logic [ADDR_W-1:0]   handle;
  } outcome_t;

  outcome_t             pending_outcomes[$];
  outcome_t             oldest;
  logic [GRANT_W-1:0]   freed_slots[MAX_SLOTS];
  int unsigned          stack_top;
  int unsigned          bump_ptr;
  int unsigned          live_slots;
  cfg_t                 regs;

  function automatic int unsigned pool_size();
    return (regs.capacity > MAX_SLOTS) ? MAX_SLOTS : regs.capacity;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_address(logic [ADDR_W-1:0] base,
                                                     logic [SLOT_W-1:0] idx);
    return base + ADDR_W'(idx) * ADDR_W'(regs.stride_bytes);
  endfunction

  // Applies one request to the shadow state and returns what the block owes.
  function automatic outcome_t serve_request(func_t op, logic [SLOT_W-1:0] idx);
    outcome_t    res;
    int unsigned cap;
    cap = pool_size();
    res = '{status: ST_OK, granted: '0, handle: '0};
    case (op)
      FUNC_ALLOC: begin
        if (live_slots >= cap) begin
          res.status = ST_FULL;
        end else if (stack_top > 0) begin
          stack_top--;
          res.granted = freed_slots[stack_top];
          live_slots++;
        end else if (bump_ptr >= cap) begin
          res.status = ST_FULL;
        end else begin
          res.granted = GRANT_W'(bump_ptr);
          bump_ptr++;
          live_slots++;
        end
      end
      FUNC_FREE: begin
        if (idx >= cap) begin
          res.status = ST_BAD_INDEX;
        end else if (stack_top >= MAX_SLOTS) begin
          res.status = ST_OVERFLOW;
        end else begin
          freed_slots[stack_top] = GRANT_W'(idx);
          stack_top++;
          if (live_slots > 0) live_slots--;
        end
      end
      FUNC_CPU_QUERY: begin
        if (idx >= cap) res.status = ST_BAD_INDEX;
        else res.handle = slot_address(regs.cpu_base, idx);
      end
      default: begin
        // Visibility is checked ahead of the index.
        if (!regs.shader_visible) res.status = ST_NOT_VISIBLE;
        else if (idx >= cap) res.status = ST_BAD_INDEX;
        else res.handle = slot_address(regs.gpu_base, idx);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stack_top  = 0;
      bump_ptr   = 0;
      live_slots = 0;
      regs = '{capacity: CAPACITY_RST, stride_bytes: STRIDE_RST, cpu_base: '0,
               gpu_base: '0, shader_visible: 1'b0};
      pending_outcomes.delete();
    end else begin
      // A result always belongs to an earlier transaction than one accepted
      // at the same edge, so it is retired first.
      if (done !== 1'b0) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with no request waiting (status %0d granted %0d handle %h)",
                   $time, status, granted, handle);
          errors++;
        end else begin
          oldest = pending_outcomes.pop_front();
          if (status !== oldest.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, oldest.status, status);
            errors++;
          end
          if (granted !== oldest.granted) begin
            $display("%0t: granted mismatch, expected %0d, got %0d",
                     $time, oldest.granted, granted);
            errors++;
          end
          if (handle !== oldest.handle) begin
            $display("%0t: handle mismatch, expected %h, got %h",
                     $time, oldest.handle, handle);
            errors++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_outcomes.insert(pending_outcomes.size(),
                                serve_request(func_t'(func), slot));
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:3])
          REG_CAPACITY:       regs.capacity       = pwdata[CNT_W-1:0];
          REG_STRIDE:         regs.stride_bytes   = pwdata[STRIDE_W-1:0];
          REG_CPU_BASE:       regs.cpu_base       = pwdata[ADDR_W-1:0];
          REG_GPU_BASE:       regs.gpu_base       = pwdata[ADDR_W-1:0];
          REG_SHADER_VISIBLE: regs.shader_visible = pwdata[0];
          default: ;
        endcase
      end
    end
    pending = pending_outcomes.size();
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the slot allocator: a directed
// pass over the corner cases, a flood of frees that fills the free stack,
// then random traffic under a series of register settings. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import sfs_pkg::*;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic [FUNC_W-1:0]   func    = FUNC_ALLOC;
  logic [SLOT_W-1:0]   slot    = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [GRANT_W-1:0]  granted;
  logic [ADDR_W-1:0]   handle;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int                  errors;
  int                  pending;
  bit                  gaps = 1'b1;
  int unsigned         pool = MAX_SLOTS_DEF;

  always #5 clk = ~clk;

  slot_allocator_free_stack_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .slot(slot),
    .done(done), .status(status), .granted(granted), .handle(handle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  slot_alloc_checker alloc_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .slot(slot),
    .done(done), .status(status), .granted(granted), .handle(handle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Entered and left at a falling edge; start stays high on exit so that the
  // next request can follow back to back.
  task automatic issue(input func_t op, input logic [SLOT_W-1:0] idx);
    while (gaps && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    func  <= op;
    slot  <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] cap, input logic [STRIDE_W-1:0] stride,
                           input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu,
                           input logic visible);
    settle();
    write_reg(REG_CAPACITY, PDATA_W'(cap));
    write_reg(REG_STRIDE, PDATA_W'(stride));
    write_reg(REG_CPU_BASE, cpu);
    write_reg(REG_GPU_BASE, gpu);
    write_reg(REG_SHADER_VISIBLE, PDATA_W'(visible));
    pool = (cap > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cap;
  endtask

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly indices inside the pool, the rest anywhere in the field.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if (pool != 0 && $urandom_range(9) < 7) return SLOT_W'($urandom_range(pool - 1));
    return SLOT_W'($urandom);
  endfunction

  task automatic random_config();
    logic [CNT_W-1:0]    cap;
    logic [STRIDE_W-1:0] stride;
    case ($urandom_range(4))
      0:       cap = CNT_W'($urandom_range(1, 8));
      1:       cap = CNT_W'($urandom_range(9, 64));
      2:       cap = CNT_W'(MAX_SLOTS_DEF);
      3:       cap = '1;
      default: cap = CNT_W'($urandom);
    endcase
    case ($urandom_range(3))
      0:       stride = '0;
      1:       stride = '1;
      default: stride = STRIDE_W'($urandom);
    endcase
    configure(cap, stride, pick_base(), pick_base(), 1'($urandom_range(1)));
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) issue(FUNC_ALLOC, SLOT_W'($urandom));
    else if (r < 65) issue(FUNC_FREE, pick_slot());
    else if (r < 82) issue(FUNC_CPU_QUERY, pick_slot());
    else issue(FUNC_GPU_QUERY, pick_slot());
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults: device queries fail before the index is looked at.
    issue(FUNC_GPU_QUERY, '0);
    issue(FUNC_GPU_QUERY, '1);
    issue(FUNC_CPU_QUERY, '0);
    issue(FUNC_CPU_QUERY, SLOT_W'(1023));
    issue(FUNC_CPU_QUERY, SLOT_W'(1024));
    issue(FUNC_ALLOC, '0);
    issue(FUNC_ALLOC, '1);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_FREE, SLOT_W'(1));
    issue(FUNC_ALLOC, '0);
    issue(FUNC_FREE, SLOT_W'(2));
    issue(FUNC_FREE, SLOT_W'(2));
    issue(FUNC_FREE, '1);
    issue(FUNC_FREE, SLOT_W'(1023));

    // Capacity above the pool size, widest stride and bases that wrap.
    configure('1, '1, '1, 64'h8000_0000_0000_0000, 1'b1);
    issue(FUNC_GPU_QUERY, '0);
    issue(FUNC_GPU_QUERY, SLOT_W'(1023));
    issue(FUNC_GPU_QUERY, SLOT_W'(1024));
    issue(FUNC_CPU_QUERY, '1);

    // Empty pool: nothing can be allocated and no index is valid.
    configure('0, '0, pick_base(), pick_base(), 1'b1);
    issue(FUNC_ALLOC, '0);
    issue(FUNC_FREE, '0);
    issue(FUNC_GPU_QUERY, '0);

    // Zero stride and a small pool that fills while the stack drains.
    configure(CNT_W'(3), '0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    issue(FUNC_CPU_QUERY, SLOT_W'(2));
    repeat (4) issue(FUNC_ALLOC, '0);

    // Fill the free stack past its depth, then pop part of it back.
    configure(CNT_W'(MAX_SLOTS_DEF), STRIDE_W'($urandom), pick_base(), pick_base(), 1'b1);
    repeat (MAX_SLOTS_DEF + 8) issue(FUNC_FREE, SLOT_W'($urandom_range(MAX_SLOTS_DEF - 1)));
    repeat (40) random_request();
    repeat (60) issue(FUNC_ALLOC, '0);

    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      gaps = (phase != 4);
      repeat (90) random_request();
    end
    gaps = 1'b1;

    settle();
    repeat (5) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
